// ===== design/brne_pkg.sv =====
// ----------------------------------------------------------------------------
// brne_pkg
// Shared types and constants for the bit run nybble encoder.
// ----------------------------------------------------------------------------
package brne_pkg;

  localparam int unsigned LimW      = 4;
  localparam int unsigned RunW      = 9;
  localparam int unsigned MaxBytes  = 3;
  localparam int unsigned CntW      = 2;

  localparam logic [LimW-1:0] LimReset = 4'd12;

  // bytes caused by one item, byte 0 goes out first
  typedef struct packed {
    logic [CntW-1:0]              cnt;
    logic [MaxBytes-1:0][7:0]     bytes;
    logic [MaxBytes-1:0]          ovf;
    logic                         eoi;
  } brne_result_t;

  // nybbles of one coded run, nybble 0 first
  typedef struct packed {
    logic [2:0][3:0] nyb;
    logic [2:0]      flg;
    logic [CntW-1:0] cnt;
  } brne_code_t;

endpackage

// ===== design/bit_run_nybble_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// bit_run_nybble_encoder_unit
// Run-length coder for monochrome bitmaps with nybble-packed byte output.
// ----------------------------------------------------------------------------
// Usage:
//   - input channel (in_valid_i / in_ready_o) takes one pixel per item in
//     row-major order, end_of_image_i set on the last pixel of an image
//   - output channel (out_valid_o / out_ready_i) gives 0 to 3 bytes per
//     item, last_of_item_o set on the final one; image_done_o and
//     run_overflow_o travel with each byte
//   - cfg_we_i writes single_run_limit from cfg_wdata_i; write it only
//     while the block is idle
//   - an item is registered in the input register and coded into the
//     result register once that register is free; its first byte is
//     valid on the output as soon as the result register holds it
//   - throughput is one item per cycle while results are taken and no item
//     has more than one byte; the result register sends one byte per cycle
//     while taken, so an item with two or three bytes holds the input side until its last byte is taken
//   - when the receiver stalls, one item waits in the input register and
//     then in_ready_o drops; nothing is lost
//   - reset clears run state and held nybble and sets the limit to 12
// ----------------------------------------------------------------------------
module bit_run_nybble_encoder_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [brne_pkg::LimW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      pixel_bit_i,
  input  logic                      end_of_image_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                out_byte_o,
  output logic                      image_done_o,
  output logic                      run_overflow_o,
  output logic                      last_of_item_o
);
  import brne_pkg::*;

  logic [LimW-1:0] limit_q;
  logic            in_vld_q;
  logic            pix_q;
  logic            eoi_q;
  logic            free;
  logic            step;
  brne_result_t    result;

  assign step       = in_vld_q && free;
  assign in_ready_o = !in_vld_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q <= pixel_bit_i;
      eoi_q <= end_of_image_i;
    end
  end

  brne_run_coder u_coder (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .pixel_bit_i    (pix_q),
    .end_of_image_i (eoi_q),
    .limit_i        (limit_q),
    .result_o       (result)
  );

  brne_out_buf u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (step),
    .result_i       (result),
    .free_o         (free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .image_done_o   (image_done_o),
    .run_overflow_o (run_overflow_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule

// ===== design/brne_run_coder.sv =====
// ----------------------------------------------------------------------------
// brne_run_coder
// Run counting, run coding and nybble pairing, one pixel per step_i cycle.
// ----------------------------------------------------------------------------
module brne_run_coder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         pixel_bit_i,
  input  logic                         end_of_image_i,
  input  logic [brne_pkg::LimW-1:0]    limit_i,
  output brne_pkg::brne_result_t       result_o
);
  import brne_pkg::*;

  logic [RunW-1:0] run_len_q, run_len_d;
  logic            run_bit_q, run_bit_d;
  logic            new_img_q, new_img_d;
  logic [3:0]      held_q, held_d;
  logic            held_vld_q, held_vld_d;
  logic            ovf_q, ovf_d;

  logic [RunW-1:0] cap;
  logic [RunW-1:0] len_mid;
  logic            ovf_mid;
  logic            run1_en;
  brne_code_t      code1, code2;
  logic [27:0]     seq_a, seq_b, seq_c;
  logic [6:0]      flg_a, flg_b, flg_c;
  logic [2:0]      n_a, n_b, n_c;
  logic [2:0]      held_idx;
  logic [27:0]     held_sh;

  function automatic brne_code_t code_run(input logic [RunW-1:0] len, input logic ovf,
                                          input logic [LimW-1:0] lim);
    brne_code_t      c;
    logic [RunW-1:0] v;
    c = '0;
    v = len - {{(RunW-LimW){1'b0}}, lim} - {{(RunW-1){1'b0}}, 1'b1};
    if (len > {{(RunW-LimW){1'b0}}, lim}) begin
      // escape nybble, then the excess over the limit less one as a byte
      c.nyb[0] = 4'h0;
      c.nyb[1] = v[7:4];
      c.nyb[2] = v[3:0];
      c.flg    = {3{ovf}};
      c.cnt    = 2'd3;
    end else begin
      c.nyb[0] = len[3:0];
      c.flg    = {2'b00, ovf};
      c.cnt    = 2'd1;
    end
    return c;
  endfunction

  // saturation point is limit + 256
  assign cap     = {1'b1, {(RunW-1-LimW){1'b0}}, limit_i};
  assign run1_en = !new_img_q && (pixel_bit_i != run_bit_q);

  always_comb begin
    run_bit_d = run_bit_q;
    len_mid   = run_len_q;
    ovf_mid   = ovf_q;
    if (new_img_q) begin
      run_bit_d = pixel_bit_i;
      len_mid   = 9'd1;
      ovf_mid   = 1'b0;
    end else if (run1_en) begin
      run_bit_d = pixel_bit_i;
      len_mid   = 9'd1;
      ovf_mid   = 1'b0;
    end else if (run_len_q < cap) begin
      len_mid   = run_len_q + 9'd1;
    end else begin
      len_mid   = cap;
      ovf_mid   = 1'b1;
    end
  end

  always_comb begin
    code1 = code_run(run_len_q, ovf_q, limit_i);
    code2 = code_run(len_mid, ovf_mid, limit_i);
    if (!run1_en) begin
      code1 = '0;
    end
    if (!end_of_image_i) begin
      code2 = '0;
    end
  end

  // nybble sequence: held nybble, finished run, closing run
  always_comb begin
    seq_a = {24'd0, held_q & {4{held_vld_q}}};
    flg_a = '0;
    n_a   = {2'b00, held_vld_q};
    seq_b = seq_a | ({16'd0, code1.nyb} << {n_a, 2'b00});
    flg_b = flg_a | ({4'd0, code1.flg} << n_a);
    n_b   = n_a + {1'b0, code1.cnt};
    seq_c = seq_b | ({16'd0, code2.nyb} << {n_b, 2'b00});
    flg_c = flg_b | ({4'd0, code2.flg} << n_b);
    n_c   = n_b + {1'b0, code2.cnt};
  end

  assign held_idx = n_c - 3'd1;
  assign held_sh  = seq_c >> {held_idx, 2'b00};

  always_comb begin
    result_o.cnt = n_c[2:1];
    result_o.eoi = end_of_image_i;
    for (int k = 0; k < MaxBytes; k++) begin
      result_o.bytes[k] = {seq_c[8*k +: 4], seq_c[8*k+4 +: 4]};
      result_o.ovf[k]   = flg_c[2*k] | flg_c[2*k+1];
    end
  end

  always_comb begin
    run_len_d  = len_mid;
    ovf_d      = ovf_mid;
    new_img_d  = 1'b0;
    held_vld_d = n_c[0];
    held_d     = n_c[0] ? held_sh[3:0] : 4'h0;
    if (end_of_image_i) begin
      run_len_d = '0;
      ovf_d     = 1'b0;
      new_img_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q  <= '0;
      run_bit_q  <= 1'b0;
      new_img_q  <= 1'b1;
      held_q     <= 4'h0;
      held_vld_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (step_i) begin
      run_len_q  <= run_len_d;
      run_bit_q  <= run_bit_d;
      new_img_q  <= new_img_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

// ===== design/brne_out_buf.sv =====
// ----------------------------------------------------------------------------
// brne_out_buf
// Result register holding one item's bytes, sent one per cycle while taken.
// ----------------------------------------------------------------------------
module brne_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  brne_pkg::brne_result_t  result_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    image_done_o,
  output logic                    run_overflow_o,
  output logic                    last_of_item_o
);
  import brne_pkg::*;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [MaxBytes-1:0]      ovf_q, ovf_d;
  logic                     eoi_q, eoi_d;
  logic                     take;

  assign take   = out_valid_o && out_ready_i;
  // free once the last byte leaves
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    ovf_d   = ovf_q;
    eoi_d   = eoi_q;
    if (load_i) begin
      cnt_d   = result_i.cnt;
      bytes_d = result_i.bytes;
      ovf_d   = result_i.ovf;
      eoi_d   = result_i.eoi;
    end else if (take) begin
      cnt_d   = cnt_q - 2'd1;
      bytes_d = {8'h00, bytes_q[2], bytes_q[1]};
      ovf_d   = {1'b0, ovf_q[2], ovf_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    ovf_q   <= ovf_d;
    eoi_q   <= eoi_d;
  end

  assign out_valid_o    = (cnt_q != 2'd0);
  assign out_byte_o     = bytes_q[0];
  assign run_overflow_o = ovf_q[0];
  assign image_done_o   = eoi_q;
  assign last_of_item_o = (cnt_q == 2'd1);

endmodule

// ===== tb/sv/bit_run_nybble_encoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_run_nybble_encoder_unit_tb
// Streams monochrome images into the run-length nybble encoder, one pixel
// per item. A directed table covers limits, escapes, saturation and held
// nybbles. Random images follow under several limit settings. Every byte
// is checked against the table's expected byte on typed rows, else against
// a cycle-free model of the coder, with random input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module bit_run_nybble_encoder_unit_tb;

  import brne_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseItems = 6;

  typedef enum logic { ROW_PIX, ROW_CFG } row_kind_e;

  // row: reps equal pixels (end_of_image on the last if eoi) or a limit write
  typedef struct packed {
    row_kind_e  kind;
    logic [8:0] reps;
    logic       pix;
    logic       eoi;
    logic       typed;
    logic [1:0] nb;
    logic [7:0] b;
    logic       ovf;
    logic [3:0] lim;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       ovf;
    logic       last;
  } enc_byte_t;

  // typed expectation that rides along with a driven item
  typedef struct packed {
    logic       typed;
    logic [1:0] nb;
    logic [7:0] b;
    logic       ovf;
  } item_tag_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LimW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic pixel_bit = 1'b0;
  logic end_of_image = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic image_done;
  logic run_overflow;
  logic last_of_item;

  bit_run_nybble_encoder_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_bit_i    (pixel_bit),
    .end_of_image_i (end_of_image),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .image_done_o   (image_done),
    .run_overflow_o (run_overflow),
    .last_of_item_o (last_of_item)
  );

  always #1 clk = ~clk;

  int unsigned cycles = 0;
  int errors = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;
  int rdy_left = 0;

  enc_byte_t pending_bytes [$];
  item_tag_t sent_tags [$];

  // coder state, mirrors the block
  logic [3:0] cur_lim = LimReset;
  logic [8:0] run_len = '0;
  logic       run_bit = 1'b0;
  logic       new_img = 1'b1;
  logic [3:0] held_nyb = '0;
  logic       held_vld = 1'b0;
  logic       ovf_seen = 1'b0;

  // bytes made by the item being coded
  logic [7:0] stg_val [MaxBytes];
  logic       stg_ovf [MaxBytes];
  int         stg_n;
  logic       stg_flag;

  function void pair_nybble(logic [3:0] nyb, logic ovf);
    if (!held_vld) begin
      held_nyb = nyb;
      stg_flag = ovf;
      held_vld = 1'b1;
    end else begin
      if (stg_n < MaxBytes) begin
        stg_val[stg_n] = {held_nyb, nyb};
        stg_ovf[stg_n] = stg_flag | ovf;
        stg_n++;
      end
      held_nyb = '0;
      stg_flag = 1'b0;
      held_vld = 1'b0;
    end
  endfunction

  function void put_run(logic [8:0] len, logic ovf);
    logic [8:0] d;
    if (len <= {5'd0, cur_lim}) begin
      pair_nybble(len[3:0], ovf);
    end else begin
      // escape: zero nybble, then the excess over the limit less one as a byte
      d = len - {5'd0, cur_lim} - 9'd1;
      pair_nybble(4'd0, ovf);
      pair_nybble(d[7:4], ovf);
      pair_nybble(d[3:0], ovf);
    end
  endfunction

  function void encode_pixel(logic pix, logic eoi);
    logic [8:0] cap;
    cap = {5'd0, cur_lim} + 9'd256;
    stg_n = 0;
    stg_flag = 1'b0;
    if (new_img) begin
      run_bit = pix;
      run_len = 9'd1;
      ovf_seen = 1'b0;
      new_img = 1'b0;
    end else if (pix != run_bit) begin
      put_run(run_len, ovf_seen);
      run_bit = pix;
      run_len = 9'd1;
      ovf_seen = 1'b0;
    end else if (run_len < cap) begin
      run_len = run_len + 9'd1;
    end else begin
      run_len = cap;
      ovf_seen = 1'b1;
    end
    if (eoi) begin
      put_run(run_len, ovf_seen);
      run_len = '0;
      ovf_seen = 1'b0;
      new_img = 1'b1;
    end
    stg_flag = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predicts on accepted items, checks accepted bytes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    enc_byte_t e;
    item_tag_t tag;
    if (out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte: out_byte %0h", out_byte);
        errors++;
      end else begin
        e = pending_bytes.pop_front();
        if (out_byte !== e.data) begin
          $error("out_byte: expected %0h, got %0h", e.data, out_byte);
          errors++;
        end
        if (image_done !== e.done) begin
          $error("image_done: expected %0b, got %0b", e.done, image_done);
          errors++;
        end
        if (run_overflow !== e.ovf) begin
          $error("run_overflow: expected %0b, got %0b", e.ovf, run_overflow);
          errors++;
        end
        if (last_of_item !== e.last) begin
          $error("last_of_item: expected %0b, got %0b", e.last, last_of_item);
          errors++;
        end
      end
    end
    if (cfg_we) cur_lim = cfg_wdata;
    if (in_valid && in_ready) begin
      tag = sent_tags.pop_front();
      encode_pixel(pixel_bit, end_of_image);
      if (tag.typed) begin
        if (tag.nb != 0) pending_bytes.push_back('{tag.b, end_of_image, tag.ovf, 1'b1});
      end else begin
        for (int k = 0; k < stg_n; k++)
          pending_bytes.push_back('{stg_val[k], end_of_image, stg_ovf[k], k == stg_n - 1});
      end
    end
  end

  // receiver back-pressure: ready bursts and stalls, mostly short
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (rdy_left == 0) begin
      if ($urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
        rdy_left = $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b0;
        rdy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end else begin
      rdy_left--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("bit_run_nybble_encoder_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function int pick_run_len(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, lim + 2);
    // escape runs, some with a nonzero high nybble in the excess byte
    return $urandom_range(lim + 3, lim + 20);
  endfunction

  task send_item(logic pix, logic eoi, logic typed, logic [1:0] nb, logic [7:0] b,
                 logic ovf);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_tags.push_back('{typed, nb, b, ovf});
    in_valid <= 1'b1;
    pixel_bit <= pix;
    end_of_image <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // hold off until all bytes are out and the pipeline has drained
  task wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task write_limit(logic [3:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task send_image(int lim);
    int nruns;
    int len;
    int n;
    logic colour;
    if ($urandom_range(0, 99) < 80) begin
      nruns = $urandom_range(1, 3);
      colour = 1'($urandom_range(0, 1));
      for (int r = 0; r < nruns; r++) begin
        len = pick_run_len(lim);
        for (int i = 0; i < len; i++)
          send_item(colour, (r == nruns - 1) && (i == len - 1), 1'b0, 2'd0, 8'd0, 1'b0);
        colour = ~colour;
      end
    end else begin
      // noise: random pixels, stray image ends
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_item(1'($urandom_range(0, 1)), (i == n - 1) || ($urandom_range(0, 7) == 0),
                  1'b0, 2'd0, 8'd0, 1'b0);
    end
  endtask

  task run_phase(logic [3:0] lim);
    int start;
    write_limit(lim);
    start = items_sent;
    while (items_sent - start < PhaseItems) send_image(int'(lim));
  endtask

  // limit 12 after reset until the first write
  dir_row_t dir_rows [0:20] = '{
    '{ROW_PIX, 9'd1,   1'b1, 1'b1, 1'b1, 2'd0, 8'h00, 1'b0, 4'd0},
    '{ROW_PIX, 9'd1,   1'b0, 1'b1, 1'b1, 2'd1, 8'h11, 1'b0, 4'd0},
    '{ROW_PIX, 9'd2,   1'b1, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 4'd0},
    '{ROW_PIX, 9'd1,   1'b1, 1'b1, 1'b1, 2'd0, 8'h00, 1'b0, 4'd0},
    '{ROW_PIX, 9'd2,   1'b0, 1'b0, 1'b1, 2'd0, 8'h00, 1'b0, 4'd0},
    // colour change on the final pixel: two runs coded by one item
    '{ROW_PIX, 9'd1,   1'b1, 1'b1, 1'b1, 2'd1, 8'h32, 1'b0, 4'd0},
    '{ROW_PIX, 9'd13,  1'b1, 1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 4'd0},
    // saturated run, one pixel past the saturation point
    '{ROW_PIX, 9'd269, 1'b0, 1'b1, 1'b1, 2'd1, 8'h0f, 1'b1, 4'd0},
    // held nybble carries no overflow mark
    '{ROW_PIX, 9'd1,   1'b1, 1'b1, 1'b1, 2'd1, 8'hf1, 1'b0, 4'd0},
    '{ROW_PIX, 9'd44,  1'b1, 1'b1, 1'b1, 2'd1, 8'h01, 1'b0, 4'd0},
    '{ROW_PIX, 9'd1,   1'b0, 1'b1, 1'b1, 2'd1, 8'hf1, 1'b0, 4'd0},
    '{ROW_PIX, 9'd12,  1'b0, 1'b1, 1'b1, 2'd0, 8'h00, 1'b0, 4'd0},
    '{ROW_PIX, 9'd1,   1'b1, 1'b1, 1'b1, 2'd1, 8'hc1, 1'b0, 4'd0},
    '{ROW_PIX, 9'd20,  1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 4'd0},
    '{ROW_PIX, 9'd1,   1'b1, 1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 4'd0},
    // limit zero: every run takes the escape form
    '{ROW_CFG, 9'd0,   1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 4'd0},
    '{ROW_PIX, 9'd1,   1'b1, 1'b1, 1'b1, 2'd1, 8'h00, 1'b0, 4'd0},
    '{ROW_CFG, 9'd0,   1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 4'd15},
    '{ROW_PIX, 9'd15,  1'b1, 1'b1, 1'b1, 2'd1, 8'h0f, 1'b0, 4'd0},
    '{ROW_PIX, 9'd16,  1'b0, 1'b1, 1'b0, 2'd0, 8'h00, 1'b0, 4'd0},
    '{ROW_CFG, 9'd0,   1'b0, 1'b0, 1'b0, 2'd0, 8'h00, 1'b0, 4'd12}
  };

  initial begin : stimulus
    dir_row_t row;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_limit(row.lim);
      end else begin
        // typed expectation belongs to the last pixel of the row
        for (int k = 0; k < row.reps; k++) begin
          if (k == row.reps - 1)
            send_item(row.pix, row.eoi, row.typed, row.nb, row.b, row.ovf);
          else
            send_item(row.pix, 1'b0, 1'b0, 2'd0, 8'd0, 1'b0);
        end
      end
    end

    run_phase(4'd0);
    run_phase(4'd15);
    no_idle = 1'b1;
    run_phase(4'd1);
    no_idle = 1'b0;
    run_phase(4'($urandom_range(2, 14)));
    run_phase(LimReset);
    run_phase(4'($urandom_range(1, 15)));

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("bit_run_nybble_encoder_unit: match");
    end else begin
      $display("bit_run_nybble_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule
